// File: sv/dtti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtti_pkg;

	// magnitude range of the parsed integer
	localparam int RESULT_BITS = 32;
	localparam int ACC_W       = RESULT_BITS;
	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int STATUS_W    = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BLANK    = 3'd2,
		ST_NOTINT   = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              no_char;
		logic              last;
	} char_item_t;

	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
	} result_t;

endpackage

`default_nettype wire

// File: sv/dtti_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtti_char_if
	import dtti_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              no_char;
	logic              last;

	modport source (output valid, output char_code, output no_char, output last, input ready);
	modport sink   (input valid, input char_code, input no_char, input last, output ready);
endinterface

`default_nettype wire

// File: sv/dtti_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dtti_result_if
	import dtti_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: sv/dtti_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module dtti_parse
	import dtti_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire char_item_t item,
	output result_t         res
);

	typedef enum logic [1:0] {
		PH_NONE,
		PH_LEAD,
		PH_BODY
	} phase_t;

	localparam logic [ACC_W-1:0] LIMIT = {1'b1, {(ACC_W-1){1'b0}}};
	localparam int EXT_W = (ACC_W > VALUE_W) ? ACC_W : VALUE_W;

	phase_t           phase_q, phase_n;
	logic             neg_q, neg_n;
	logic [ACC_W-1:0] acc_q, acc_n;
	logic             seen_q, seen_n;
	logic             space_q, space_n;
	status_t          err_q, err_n;

	logic             white, digit, sign, done;
	logic [3:0]       dval;
	logic [ACC_W+3:0] acc_x10;
	logic             ovf;
	logic [EXT_W-1:0] mag_ext, val_ext;

	function automatic logic is_white(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	always_comb begin
		white   = is_white(item.char_code);
		digit   = (item.char_code >= "0") && (item.char_code <= "9");
		sign    = (item.char_code == "-") || (item.char_code == "+");
		dval    = 4'(item.char_code - "0");
		// ten times the magnitude plus the new digit, checked against the limit
		acc_x10 = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (ACC_W+4)'(dval);
		ovf     = acc_x10 > (ACC_W+4)'(LIMIT);

		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		seen_n  = seen_q;
		space_n = space_q;
		err_n   = err_q;
		done    = 1'b0;
		res     = '0;
		mag_ext = '0;
		val_ext = '0;

		if (take && !item.no_char) begin
			if (phase_q != PH_BODY) begin
				if (white) begin
					phase_n = PH_LEAD;
					done    = 1'b1;
				end else begin
					phase_n = PH_BODY;
					if (sign) begin
						neg_n = (item.char_code == "-");
						done  = 1'b1;
					end
				end
			end
			if (!done && err_q == ST_OK) begin
				if (white) begin
					space_n = 1'b1;
				end else if (space_q) begin
					err_n = ST_NOTINT;
				end else if (digit) begin
					if (ovf) begin
						err_n = ST_OVERFLOW;
					end else begin
						acc_n  = acc_x10[ACC_W-1:0];
						seen_n = 1'b1;
					end
				end else begin
					err_n = ST_NOTINT;
				end
			end
		end

		if (take && item.last) begin
			res.valid = 1'b1;
			mag_ext   = EXT_W'(acc_n);
			val_ext   = neg_n ? (EXT_W'(0) - mag_ext) : mag_ext;
			if (phase_n == PH_NONE) begin
				res.status = ST_EMPTY;
			end else if (phase_n == PH_LEAD) begin
				res.status = ST_BLANK;
			end else if (err_n != ST_OK) begin
				res.status = err_n;
			end else if (!seen_n) begin
				res.status = ST_NOTINT;
			end else if (!neg_n && acc_n == LIMIT) begin
				res.status = ST_OVERFLOW;
			end else begin
				res.status = ST_OK;
				res.value  = val_ext[VALUE_W-1:0];
			end
			// ready for the next string
			phase_n = PH_NONE;
			neg_n   = 1'b0;
			acc_n   = '0;
			seen_n  = 1'b0;
			space_n = 1'b0;
			err_n   = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			seen_q  <= 1'b0;
			space_q <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			acc_q   <= acc_n;
			seen_q  <= seen_n;
			space_q <= space_n;
			err_q   <= err_n;
		end
	end

endmodule

`default_nettype wire

// File: sv/decimal_text_to_integer.sv
// decimal text to integer converter
// chars (sink): one byte of a string per transfer, with no_char for an item
//   that carries no character and last on the final item of the string
// results (source): one transfer per string, at its last item, carrying the
//   signed value and a status (success, empty, blank, not an integer,
//   overflow); value is zero unless the status is success
// a result is offered from the result register: the last item passes the
//   input register, then is parsed into the result register once consumed
// throughput: one character per cycle unless the input stalls; the parse
//   state (magnitude, sign, error) is updated by a single times-ten add and
//   limit compare per cycle
// when the result receiver stalls, the result register holds; further
//   characters keep flowing until a second last item reaches the parse
//   stage, which then waits, and the input stalls behind it
// reset: asynchronous, active low; clears all parse state, empties both
//   registers, so the first byte after reset starts a new string
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_integer
	import dtti_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	dtti_char_if.sink    chars,
	dtti_result_if.source results
);

	// input register stage
	char_item_t item_s1;
	logic       v_s1;
	logic       consume;

	// result register
	result_t    res;
	logic       out_v_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [STATUS_W-1:0]       out_status_q;

	// a last item needs room in the result register, other items always go
	assign consume     = v_s1 && (!item_s1.last || !out_v_q || results.ready);
	assign chars.ready = !v_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (chars.ready) begin
			v_s1 <= chars.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1.char_code <= chars.char_code;
			item_s1.no_char   <= chars.no_char;
			item_s1.last      <= chars.last;
		end
	end

	dtti_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (consume),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.valid) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_value_q  <= res.value;
			out_status_q <= res.status;
		end
	end

	assign results.valid  = out_v_q;
	assign results.value  = out_value_q;
	assign results.status = out_status_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dtti_pkg::*;

	// character codes the parser treats specially
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	// largest magnitude a negative result may take, 2^(RESULT_BITS-1)
	localparam longint unsigned MAG_LIMIT = 64'd1 << (RESULT_BITS - 1);

	localparam int RANDOM_ITEMS  = 2000;
	localparam int HOLD_CYCLES   = 60;
	localparam int DRAIN_CYCLES  = 8;
	localparam int TIMEOUT_NS    = 2_000_000;

	// where the scan of the current string stands
	typedef enum logic [1:0] {
		SCAN_NONE,
		SCAN_LEAD,
		SCAN_BODY
	} scan_phase_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
	} conversion_t;

	logic clk = 1'b0;
	logic arst_n;

	dtti_char_if   char_bus();
	dtti_result_if result_bus();

	decimal_text_to_integer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.results(result_bus)
	);

	always #5 clk = ~clk;

	// characters still to be offered, and conversions still to arrive
	char_item_t  char_stream_q[$];
	conversion_t awaited_conversions[$];
	logic [CHAR_W-1:0] text_buf[$];

	int   total_items   = 0;
	int   items_taken   = 0;
	int   mismatch_count = 0;
	logic char_taken    = 1'b0;
	logic hold_off      = 1'b0;

	// own copy of the parse state
	scan_phase_t     sc_phase;
	logic            sc_negative;
	longint unsigned sc_mag;
	logic            sc_digit;
	logic            sc_gap;
	status_t         sc_err;

	function automatic logic is_blank_byte(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void clear_scan();
		sc_phase    = SCAN_NONE;
		sc_negative = 1'b0;
		sc_mag      = 0;
		sc_digit    = 1'b0;
		sc_gap      = 1'b0;
		sc_err      = ST_OK;
	endfunction

	// one character into the scan state; only the first error is kept
	function automatic void scan_byte(logic [CHAR_W-1:0] c);
		longint unsigned d;
		if (sc_phase != SCAN_BODY) begin
			if (is_blank_byte(c)) begin
				sc_phase = SCAN_LEAD;
				return;
			end
			sc_phase = SCAN_BODY;
			if (c == CH_MINUS || c == CH_PLUS) begin
				sc_negative = (c == CH_MINUS);
				return;
			end
		end
		if (sc_err != ST_OK)
			return;
		if (is_blank_byte(c)) begin
			sc_gap = 1'b1;
			return;
		end
		if (sc_gap) begin
			sc_err = ST_NOTINT;
			return;
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 64'(c - CH_ZERO);
			if (sc_mag > (MAG_LIMIT - d) / 10) begin
				sc_err = ST_OVERFLOW;
				return;
			end
			sc_mag   = sc_mag * 10 + d;
			sc_digit = 1'b1;
			return;
		end
		sc_err = ST_NOTINT;
	endfunction

	// expected conversion for a transferred item, if it closes a string
	function automatic void convert_text_item(char_item_t it);
		conversion_t r;
		if (!it.no_char)
			scan_byte(it.char_code);
		if (!it.last)
			return;
		r.value = '0;
		if (sc_phase == SCAN_NONE)
			r.status = ST_EMPTY;
		else if (sc_phase == SCAN_LEAD)
			r.status = ST_BLANK;
		else if (sc_err != ST_OK)
			r.status = sc_err;
		else if (!sc_digit)
			r.status = ST_NOTINT;
		else if (!sc_negative && sc_mag == MAG_LIMIT)
			r.status = ST_OVERFLOW;
		else begin
			r.status = ST_OK;
			r.value  = VALUE_W'(sc_negative ? 64'd0 - sc_mag : sc_mag);
		end
		awaited_conversions.push_back(r);
		clear_scan();
	endfunction

	// stimulus building
	function automatic void push_char(logic [CHAR_W-1:0] c, logic nc, logic lst);
		char_item_t it;
		it.char_code = c;
		it.no_char   = nc;
		it.last      = lst;
		char_stream_q.push_back(it);
	endfunction

	function automatic logic [CHAR_W-1:0] pick_blank();
		if ($urandom_range(2, 0) == 0)
			return CH_SPACE;
		return CH_TAB + CHAR_W'($urandom_range(4, 0));
	endfunction

	function automatic void add_digits(longint unsigned mag);
		string dig;
		dig = $sformatf("%0d", mag);
		for (int i = 0; i < dig.len(); i++)
			text_buf.push_back(dig[i]);
	endfunction

	// text_buf as one string; empty items sprinkled in, sometimes an empty closing item
	function automatic void flush_text(logic close_empty);
		int n;
		n = text_buf.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9, 0) == 0)
				push_char(CHAR_W'($urandom_range(255, 0)), 1'b1, 1'b0);
			push_char(text_buf[i], 1'b0, (i == n - 1) && !close_empty);
		end
		if (n == 0 || close_empty)
			push_char(CHAR_W'($urandom_range(255, 0)), 1'b1, 1'b1);
		text_buf.delete();
	endfunction

	// mostly well-formed numbers with random content, the rest broken
	function automatic void gen_random_text();
		longint unsigned mag;
		int              pos;
		int              flaw;
		text_buf.delete();
		repeat ($urandom_range(2, 0)) text_buf.push_back(pick_blank());
		case ($urandom_range(2, 0))
			1: text_buf.push_back(CH_MINUS);
			2: text_buf.push_back(CH_PLUS);
			default: ;
		endcase
		case ($urandom_range(5, 0))
			0: mag = $urandom_range(9, 0);
			1: mag = $urandom_range(99999, 0);
			2: mag = $urandom;
			// either side of the signed limit
			3: mag = MAG_LIMIT - 1 + $urandom_range(2, 0);
			// usually well past the limit
			4: mag = longint'($urandom) * $urandom_range(99, 2);
			default: begin
				repeat ($urandom_range(3, 1)) text_buf.push_back(CH_ZERO);
				mag = $urandom_range(999, 0);
			end
		endcase
		add_digits(mag);
		repeat ($urandom_range(2, 0)) text_buf.push_back(pick_blank());

		if ($urandom_range(99, 0) < 30) begin
			flaw = $urandom_range(5, 0);
			pos  = $urandom_range(text_buf.size(), 0);
			case (flaw)
				0: begin
					// any byte at all in place of one character
					if (pos == text_buf.size())
						pos = pos - 1;
					text_buf[pos] = CHAR_W'($urandom_range(255, 0));
				end
				1: text_buf.insert(pos, pick_blank());
				2: text_buf.insert(pos, $urandom_range(1, 0) ? CH_MINUS : CH_PLUS);
				3: begin
					// white space only
					text_buf.delete();
					repeat ($urandom_range(3, 1)) text_buf.push_back(pick_blank());
				end
				4: text_buf.delete();
				default: begin
					// a sign with no digit behind it
					text_buf.delete();
					repeat ($urandom_range(1, 0)) text_buf.push_back(pick_blank());
					text_buf.push_back($urandom_range(1, 0) ? CH_MINUS : CH_PLUS);
					repeat ($urandom_range(1, 0)) text_buf.push_back(pick_blank());
				end
			endcase
		end
		flush_text($urandom_range(9, 0) == 0);
	endfunction

	// idling by stage of the run: sender 38 / receiver 73, then swapped, then none
	function automatic int sender_idle_pct();
		case (items_taken * 3 / total_items)
			0: return 38;
			1: return 73;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (items_taken * 3 / total_items)
			0: return 73;
			1: return 38;
			default: return 0;
		endcase
	endfunction

	// driver: a new character is offered only once the previous one made its transfer
	always @(negedge clk) begin : char_driver
		char_item_t next_item;
		if (arst_n && (!char_bus.valid || char_taken)) begin
			if (char_stream_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct()) begin
				next_item           = char_stream_q.pop_front();
				char_bus.valid     <= 1'b1;
				char_bus.char_code <= next_item.char_code;
				char_bus.no_char   <= next_item.no_char;
				char_bus.last      <= next_item.last;
			end else
				char_bus.valid <= 1'b0;
		end
	end

	// receiver readiness, held low for the whole of a hold-off
	always @(negedge clk) begin
		if (!arst_n)
			result_bus.ready <= 1'b0;
		else
			result_bus.ready <= !hold_off && $urandom_range(99, 0) >= receiver_idle_pct();
	end

	// input side monitor: every character transfer feeds the predictor
	always @(posedge clk) begin : char_monitor
		char_item_t seen;
		char_taken <= char_bus.valid && char_bus.ready;
		if (char_bus.valid && char_bus.ready) begin
			seen.char_code = char_bus.char_code;
			seen.no_char   = char_bus.no_char;
			seen.last      = char_bus.last;
			convert_text_item(seen);
			items_taken <= items_taken + 1;
		end
	end

	// output side monitor: each result transfer against the oldest conversion awaited
	always @(posedge clk) begin : result_monitor
		conversion_t want;
		if (result_bus.valid && result_bus.ready) begin
			if (awaited_conversions.size() == 0) begin
				$display("%0t: result with none awaited: expected nothing, actual value %0d status %0d",
					$time, result_bus.value, result_bus.status);
				mismatch_count++;
			end else begin
				want = awaited_conversions.pop_front();
				if (result_bus.value !== want.value) begin
					$display("%0t: value mismatch: expected %0d, actual %0d",
						$time, want.value, result_bus.value);
					mismatch_count++;
				end
				if (result_bus.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, result_bus.status);
					mismatch_count++;
				end
			end
		end
	end

	// long receiver hold-off once the sender no longer idles, so the block fills and stalls
	initial begin
		while (total_items == 0 || items_taken < 2 * total_items / 3 + 20)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#TIMEOUT_NS;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		char_bus.valid      = 1'b0;
		char_bus.char_code  = '0;
		char_bus.no_char    = 1'b0;
		char_bus.last       = 1'b0;
		result_bus.ready    = 1'b0;
		clear_scan();

		// directed: empty, blank, lone sign, top byte, nul byte, zero, both limits
		flush_text(1'b0);
		text_buf.push_back(CH_SPACE);
		flush_text(1'b0);
		push_char(CH_PLUS, 1'b0, 1'b1);
		push_char(8'hFF, 1'b0, 1'b1);
		push_char(8'h00, 1'b0, 1'b1);
		push_char(CH_ZERO, 1'b0, 1'b1);
		text_buf.push_back(CH_MINUS);
		add_digits(MAG_LIMIT);
		foreach (text_buf[i])
			push_char(text_buf[i], 1'b0, i == text_buf.size() - 1);
		text_buf.delete();
		add_digits(MAG_LIMIT);
		foreach (text_buf[i])
			push_char(text_buf[i], 1'b0, i == text_buf.size() - 1);
		text_buf.delete();

		while (char_stream_q.size() < RANDOM_ITEMS)
			gen_random_text();
		total_items = char_stream_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every character transferred, every conversion back, then let the pipeline drain
		while (items_taken != total_items)
			@(posedge clk);
		while (awaited_conversions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
